### src/pic_pkg.sv
// Shared types, constants and a helper function of the incremental PI controller.
`default_nettype none

package pic_pkg;

   // Fixed-point constants in Q16.16.
   localparam int unsigned ERR_W  = 33;
   localparam int unsigned FRAC_W = 16;
   localparam logic signed [31:0] DT_MAX_Q = 32'sd196608;
   localparam logic signed [32:0] ONE_Q    = 33'sd65536;

   // Multiplier and accumulator widths.
   localparam int unsigned MUL_A_W  = 32;
   localparam int unsigned MUL_B_W  = 17;
   localparam int unsigned MUL_P_W  = MUL_A_W + MUL_B_W;
   localparam int unsigned PROD_W   = MUL_P_W + FRAC_W;
   localparam int unsigned SHIFT_W  = PROD_W - FRAC_W;
   localparam int unsigned SUM_W    = 51;

   // Configuration register indexes.
   localparam int unsigned CSR_IDX_W = 3;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P        = 3'd0,
      CSR_INTEGRAL_TIME = 3'd1,
      CSR_OUT_MAX       = 3'd2,
      CSR_OUT_MIN       = 3'd3,
      CSR_DEADBAND      = 3'd4
   } csr_index_type;

   // Input operation codes.
   localparam logic OP_STEP  = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   // Result of the serial divider, handed to the sequencer.
   typedef struct packed {
      logic              done;
      logic signed [31:0] ratio;
   } div_result_type;

   // Saturate a wide signed value into 32 bits.
   function automatic logic signed [31:0] sat32(input logic signed [SHIFT_W-1:0] v);
      logic signed [SHIFT_W-1:0] hi_lim;
      logic signed [SHIFT_W-1:0] lo_lim;
      hi_lim = SHIFT_W'(64'sh7FFF_FFFF);
      lo_lim = SHIFT_W'(-64'sh8000_0000);
      if (v > hi_lim) begin
         return 32'sh7FFF_FFFF;
      end else if (v < lo_lim) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

endpackage

`default_nettype wire

### src/pic_if.sv
// Handshake interfaces of the request and response channels.
`default_nettype none

interface pic_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic signed [31:0] time_step;
   logic signed [31:0] setpoint;
   logic signed [31:0] measured;

   modport source (output valid, op, time_step, setpoint, measured, input ready);
   modport sink   (input valid, op, time_step, setpoint, measured, output ready);
endinterface

interface pic_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] drive;

   modport source (output valid, drive, input ready);
   modport sink   (input valid, drive, output ready);
endinterface

`default_nettype wire

### src/incremental_pi_controller.sv
// Top level of the velocity-form PI controller with a shared serial multiplier.
//
// Usage: request transactions carry op, time_step, setpoint and measured, all
// Q16.16. A clear transaction (op high) zeroes the stored error and drive and
// gives no response. A step with a time step of zero or above 3.0 is dropped
// with no response and no state change. Any other step gives one response
// transaction carrying the new clamped drive.
// Sequence: with a nonzero integral time an accepted step passes through the
// serial divider for dt / integral time, the factor state, three products on
// one 32 x 17 multiplier, each in high, low and end states, and the clamp
// state, which loads the response register. With integral time zero the
// divider and gain product are skipped; clear and dropped items finish in idle.
// Throughput: one item at a time; req ready is high only while the sequencer is
// idle. A result waiting in the response register does not block the next item;
// if the receiver stalls, a finished step holds in its clamp state until the
// register is free. Reset: synchronous, active high; registers go to their
// default values and the stored error and drive go to zero. Configuration
// writes take effect at once; the user must make them only while the block is
// idle, as the block itself does not enforce it.
`default_nettype none

module incremental_pi_controller (
   input  wire logic                              clock,
   input  wire logic                              reset,
   pic_req_if.sink                                req_ch,
   pic_rsp_if.source                              rsp_ch,
   input  wire logic                              csr_write_enable,
   input  wire logic [pic_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [31:0]                       csr_write_data
);

   // Sequencer states.
   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DIV    = 7'b0000010,
      ST_FACTOR = 7'b0000100,
      ST_MUL_HI = 7'b0001000,
      ST_MUL_LO = 7'b0010000,
      ST_MUL_END = 7'b0100000,
      ST_CLAMP  = 7'b1000000
   } state_type;

   // Which product the shared multiplier is forming.
   typedef enum logic [1:0] {
      PROD_GAIN = 2'd0,
      PROD_ERR  = 2'd1,
      PROD_PREV = 2'd2
   } prod_type;

   state_type state_ff, state_in;
   prod_type  prod_ff, prod_in;

   // Configuration registers.
   logic signed [31:0] gain_p_ff, gain_p_in;
   logic [30:0]        integral_time_ff, integral_time_in;
   logic signed [31:0] out_max_ff, out_max_in;
   logic signed [31:0] out_min_ff, out_min_in;
   logic [30:0]        deadband_ff, deadband_in;

   // Controller state and working registers.
   logic signed [pic_pkg::ERR_W-1:0]   prev_err_ff, prev_err_in;
   logic signed [31:0]                 prev_drive_ff, prev_drive_in;
   logic signed [pic_pkg::ERR_W-1:0]   err_ff, err_in;
   logic signed [31:0]                 factor_ff, factor_in;
   logic signed [31:0]                 gain_a_ff, gain_a_in;
   logic signed [pic_pkg::PROD_W-1:0]  prod_acc_ff, prod_acc_in;
   logic signed [pic_pkg::SUM_W-1:0]   sum_ff, sum_in;
   logic                               inband_ff;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]                 drive_ff, drive_in;

   logic                               accept;
   logic                               step_ok;
   logic                               div_start;
   pic_pkg::div_result_type            div_res;
   logic signed [32:0]                 factor_sum;
   logic signed [pic_pkg::MUL_A_W-1:0] mul_a;
   logic signed [pic_pkg::ERR_W-1:0]   mul_b_full;
   logic signed [pic_pkg::MUL_B_W-1:0] mul_b;
   logic signed [pic_pkg::MUL_P_W-1:0] mul_p;
   logic signed [pic_pkg::SHIFT_W-1:0] prod_shift;
   logic [31:0]                        err_mag;
   logic signed [pic_pkg::SUM_W-1:0]   cand0;
   logic signed [pic_pkg::SUM_W-1:0]   cand1;
   logic signed [pic_pkg::SUM_W-1:0]   cand2;
   logic                               rsp_free;

   // Handshakes.
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign step_ok      = (req_ch.time_step != 32'sd0) &&
                         (req_ch.time_step <= pic_pkg::DT_MAX_Q);
   assign div_start    = accept && (req_ch.op == pic_pkg::OP_STEP) && step_ok &&
                         (integral_time_ff != 31'd0);
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.drive = drive_ff;

   pic_div u_div (
      .clock         (clock),
      .reset         (reset),
      .start         (div_start),
      .time_step     (req_ch.time_step),
      .integral_time (integral_time_ff),
      .result        (div_res)
   );

   // Integral factor 1 + dt/ti; only positive overflow is possible.
   assign factor_sum = {div_res.ratio[31], div_res.ratio} + pic_pkg::ONE_Q;

   // Shared multiplier: the wide operand is split into a signed upper part and
   // an unsigned lower 16 bits, and the two partial products are accumulated.
   always_comb begin
      unique case (prod_ff)
         PROD_GAIN: begin
            mul_a      = gain_p_ff;
            mul_b_full = {factor_ff[31], factor_ff};
         end
         PROD_ERR: begin
            mul_a      = gain_a_ff;
            mul_b_full = err_ff;
         end
         PROD_PREV: begin
            mul_a      = gain_p_ff;
            mul_b_full = prev_err_ff;
         end
         default: begin
            mul_a      = gain_p_ff;
            mul_b_full = prev_err_ff;
         end
      endcase
      if (state_ff == ST_MUL_HI) begin
         mul_b = mul_b_full[pic_pkg::ERR_W-1:pic_pkg::FRAC_W];
      end else begin
         mul_b = {1'b0, mul_b_full[pic_pkg::FRAC_W-1:0]};
      end
   end

   assign mul_p      = mul_a * mul_b;
   assign prod_shift = prod_acc_ff[pic_pkg::PROD_W-1:pic_pkg::FRAC_W];

   // Error magnitude for the deadband test.
   assign err_mag = err_ff[32] ? 32'(-err_ff) : err_ff[31:0];

   // Deadband forces a zero candidate; the lower clamp is applied last.
   assign cand0 = inband_ff ? '0 : sum_ff;
   assign cand1 = (cand0 > pic_pkg::SUM_W'(out_max_ff)) ?
                  pic_pkg::SUM_W'(out_max_ff) : cand0;
   assign cand2 = (cand1 < pic_pkg::SUM_W'(out_min_ff)) ?
                  pic_pkg::SUM_W'(out_min_ff) : cand1;

   // Configuration writes.
   always_comb begin
      gain_p_in        = gain_p_ff;
      integral_time_in = integral_time_ff;
      out_max_in       = out_max_ff;
      out_min_in       = out_min_ff;
      deadband_in      = deadband_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            pic_pkg::CSR_GAIN_P:        gain_p_in        = csr_write_data;
            pic_pkg::CSR_INTEGRAL_TIME: integral_time_in = csr_write_data[30:0];
            pic_pkg::CSR_OUT_MAX:       out_max_in       = csr_write_data;
            pic_pkg::CSR_OUT_MIN:       out_min_in       = csr_write_data;
            pic_pkg::CSR_DEADBAND:      deadband_in      = csr_write_data[30:0];
            default: begin
            end
         endcase
      end
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      prod_in       = prod_ff;
      prev_err_in   = prev_err_ff;
      prev_drive_in = prev_drive_ff;
      err_in        = err_ff;
      factor_in     = factor_ff;
      gain_a_in     = gain_a_ff;
      prod_acc_in   = prod_acc_ff;
      sum_in        = sum_ff;
      drive_in      = drive_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_ch.op == pic_pkg::OP_CLEAR) begin
                  prev_err_in   = '0;
                  prev_drive_in = '0;
               end else if (step_ok) begin
                  err_in = {req_ch.setpoint[31], req_ch.setpoint} -
                           {req_ch.measured[31], req_ch.measured};
                  if (integral_time_ff == 31'd0) begin
                     gain_a_in = gain_p_ff;
                     prod_in   = PROD_ERR;
                     state_in  = ST_MUL_HI;
                  end else begin
                     state_in = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               factor_in = pic_pkg::sat32(pic_pkg::SHIFT_W'(factor_sum));
               state_in  = ST_FACTOR;
            end
         end
         ST_FACTOR: begin
            prod_in  = PROD_GAIN;
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            prod_acc_in = {mul_p, {pic_pkg::FRAC_W{1'b0}}};
            state_in    = ST_MUL_LO;
         end
         ST_MUL_LO: begin
            prod_acc_in = prod_acc_ff + pic_pkg::PROD_W'(mul_p);
            state_in    = ST_MUL_END;
         end
         ST_MUL_END: begin
            // Floor of the product over 2^16, used by the current term.
            unique case (prod_ff)
               PROD_GAIN: begin
                  gain_a_in = pic_pkg::sat32(prod_shift);
                  prod_in   = PROD_ERR;
                  state_in  = ST_MUL_HI;
               end
               PROD_ERR: begin
                  sum_in   = pic_pkg::SUM_W'(prev_drive_ff) + pic_pkg::SUM_W'(prod_shift);
                  prod_in  = PROD_PREV;
                  state_in = ST_MUL_HI;
               end
               default: begin
                  sum_in   = sum_ff - pic_pkg::SUM_W'(prod_shift);
                  state_in = ST_CLAMP;
               end
            endcase
         end
         ST_CLAMP: begin
            if (rsp_free) begin
               drive_in      = cand2[31:0];
               prev_drive_in = cand2[31:0];
               prev_err_in   = err_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         prod_ff          <= PROD_GAIN;
         rsp_valid_ff     <= 1'b0;
         prev_err_ff      <= '0;
         prev_drive_ff    <= '0;
         gain_p_ff        <= 32'sd0;
         integral_time_ff <= 31'd0;
         out_max_ff       <= 32'sd65536;
         out_min_ff       <= -32'sd65536;
         deadband_ff      <= 31'd655;
      end else begin
         state_ff         <= state_in;
         prod_ff          <= prod_in;
         rsp_valid_ff     <= rsp_valid_in;
         prev_err_ff      <= prev_err_in;
         prev_drive_ff    <= prev_drive_in;
         gain_p_ff        <= gain_p_in;
         integral_time_ff <= integral_time_in;
         out_max_ff       <= out_max_in;
         out_min_ff       <= out_min_in;
         deadband_ff      <= deadband_in;
      end
      err_ff      <= err_in;
      factor_ff   <= factor_in;
      gain_a_ff   <= gain_a_in;
      prod_acc_ff <= prod_acc_in;
      sum_ff      <= sum_in;
      drive_ff    <= drive_in;
      inband_ff   <= ({1'b0, err_mag} < {2'b00, deadband_ff});
   end

endmodule

`default_nettype wire

### src/pic_div.sv
// Radix-2 restoring divider forming the saturated ratio dt * 2^16 / integral time.
`default_nettype none

module pic_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic signed [31:0]        time_step,
   input  wire logic [30:0]               integral_time,
   output pic_pkg::div_result_type        result
);

   logic        busy_ff, busy_in;
   logic        fix_ff, fix_in;
   logic        done_ff, done_in;
   logic [4:0]  count_ff, count_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quot_ff, quot_in;
   logic        neg_ff, neg_in;
   logic        ovf_ff, ovf_in;
   logic signed [31:0] ratio_ff, ratio_in;

   logic [31:0] dt_abs;
   logic [31:0] rem_shift;
   logic [32:0] trial;
   logic        qbit;

   // Magnitude of the time step; the dividend is this value shifted up by 16 bits.
   assign dt_abs    = time_step[31] ? 32'(-time_step) : 32'(time_step);
   assign rem_shift = {rem_ff[30:0], quot_ff[31]};
   assign trial     = {1'b0, rem_shift} - {2'b00, integral_time};
   assign qbit      = ~trial[32];

   // One quotient bit per cycle; the quotient shifts into the dividend register.
   always_comb begin
      busy_in  = busy_ff;
      fix_in   = 1'b0;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      ratio_in = ratio_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = 5'd31;
         rem_in   = {16'd0, dt_abs[31:16]};
         quot_in  = {dt_abs[15:0], 16'd0};
         neg_in   = time_step[31];
         // A quotient of 2^32 or more shows in the upper dividend half alone.
         ovf_in   = ({15'd0, dt_abs[31:16]} >= integral_time);
      end else if (busy_ff) begin
         rem_in   = qbit ? trial[31:0] : rem_shift;
         quot_in  = {quot_ff[30:0], qbit};
         count_in = count_ff - 5'd1;
         if (count_ff == 5'd0) begin
            busy_in = 1'b0;
            fix_in  = 1'b1;
         end
      end
      // Apply the sign and saturate to signed 32 bits.
      if (fix_ff) begin
         done_in = 1'b1;
         if (!neg_ff) begin
            ratio_in = (ovf_ff || quot_ff[31]) ? 32'sh7FFF_FFFF : quot_ff;
         end else if (ovf_ff || (quot_ff > 32'h8000_0000)) begin
            ratio_in = 32'sh8000_0000;
         end else begin
            ratio_in = -quot_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      neg_ff   <= neg_in;
      ovf_ff   <= ovf_in;
      ratio_ff <= ratio_in;
   end

   assign result.done  = done_ff;
   assign result.ratio = ratio_ff;

endmodule

`default_nettype wire

### bench/tb_incremental_pi_controller.sv
// Self-checking testbench of the incremental PI controller, with its own drive predictor.
`default_nettype none

module tb_incremental_pi_controller;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint Q_ONE      = 65536;
   localparam int     HOLD_OFF   = 64;
   localparam int     STALL_LIMIT = 3000;
   localparam int     PHASE_STEPS = 180;
   localparam int     RANDOM_PHASES = 8;

   // One request transaction as the sender sees it.
   typedef struct {
      logic               op;
      logic signed [31:0] time_step;
      logic signed [31:0] setpoint;
      logic signed [31:0] measured;
   } pi_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                          csr_write_enable = 1'b0;
   logic [pic_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]                   csr_write_data = '0;

   pic_req_if req_bus ();
   pic_rsp_if rsp_bus ();

   incremental_pi_controller i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_bus),
      .rsp_ch           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Predictor copy of the registers and of the stored controller state.
   logic signed [31:0] cfg_gain      = 32'sd0;
   logic        [30:0] cfg_itime     = 31'd0;
   logic signed [31:0] cfg_out_max   = 32'sd65536;
   logic signed [31:0] cfg_out_min   = -32'sd65536;
   logic        [30:0] cfg_deadband  = 31'd655;
   logic signed [32:0] ctl_prev_err   = '0;
   logic signed [31:0] ctl_prev_drive = '0;

   pi_req_type         pending_reqs[$];
   logic signed [31:0] drive_expect[$];
   int                 mismatch_count = 0;
   int                 req_idle_pct = 0;
   int                 rsp_idle_pct = 0;
   int                 send_gap = 0;
   int                 rsp_stall = 0;
   int                 quiet_cycles = 0;

   always #1 clock = ~clock;

   task automatic log_mismatch(input string msg);
      $display("MISMATCH at %0t: %0s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic longint clip_q16(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Advance the controller state for one accepted transaction and queue the drive it yields.
   task automatic predict_drive(input pi_req_type it);
      longint dt, err, a_coef, ratio, delta, cand, mag;
      if (it.op == pic_pkg::OP_CLEAR) begin
         ctl_prev_err = '0;
         ctl_prev_drive = '0;
         return;
      end
      dt = longint'(it.time_step);
      if (dt == 0 || dt > longint'(pic_pkg::DT_MAX_Q)) begin
         return;
      end
      err = longint'(it.setpoint) - longint'(it.measured);
      if (cfg_itime == '0) begin
         a_coef = longint'(cfg_gain);
      end else begin
         ratio = clip_q16((dt * Q_ONE) / longint'(cfg_itime));
         a_coef = clip_q16((longint'(cfg_gain) * clip_q16(Q_ONE + ratio)) >>> 16);
      end
      delta = ((a_coef * err) >>> 16) - ((longint'(cfg_gain) * longint'(ctl_prev_err)) >>> 16);
      mag = (err < 0) ? -err : err;
      if (mag < longint'(cfg_deadband)) begin
         cand = 0;
      end else begin
         cand = longint'(ctl_prev_drive) + delta;
      end
      // The lower clamp is applied last, so it wins when the limits cross.
      if (cand > longint'(cfg_out_max)) cand = longint'(cfg_out_max);
      if (cand < longint'(cfg_out_min)) cand = longint'(cfg_out_min);
      ctl_prev_drive = cand[31:0];
      ctl_prev_err = err[32:0];
      drive_expect.push_back(cand[31:0]);
   endtask

   // Request driver: presents queued items and inserts idle bursts between them.
   always @(posedge clock) begin : req_driver
      pi_req_type seen;
      pi_req_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            seen.op = req_bus.op;
            seen.time_step = req_bus.time_step;
            seen.setpoint = req_bus.setpoint;
            seen.measured = req_bus.measured;
            predict_drive(seen);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_bus.valid <= 1'b0;
            end else if (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct) begin
               send_gap <= $urandom_range(0, 13);
               req_bus.valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               nxt = pending_reqs.pop_front();
               req_bus.op <= nxt.op;
               req_bus.time_step <= nxt.time_step;
               req_bus.setpoint <= nxt.setpoint;
               req_bus.measured <= nxt.measured;
               req_bus.valid <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each drive against the oldest prediction and stalls in bursts.
   always @(posedge clock) begin : rsp_monitor
      logic signed [31:0] want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (drive_expect.size() == 0) begin
               log_mismatch($sformatf("unexpected response, drive %0d", rsp_bus.drive));
            end else begin
               want = drive_expect.pop_front();
               if (rsp_bus.drive !== want) begin
                  log_mismatch($sformatf("drive %0d, predicted %0d", rsp_bus.drive, want));
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall <= rsp_stall - 1;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_bus.ready && rsp_idle_pct != 0
                      && $urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_stall <= $urandom_range(0, 13);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Watchdog: the run ends when no transaction moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", quiet_cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Wait until every item is taken and every drive has come back, then let the block settle.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_bus.valid || drive_expect.size() != 0);
      repeat (HOLD_OFF) @(negedge clock);
   endtask

   task automatic write_csr(input pic_pkg::csr_index_type idx, input logic [31:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         pic_pkg::CSR_GAIN_P:        cfg_gain = data;
         pic_pkg::CSR_INTEGRAL_TIME: cfg_itime = data[30:0];
         pic_pkg::CSR_OUT_MAX:       cfg_out_max = data;
         pic_pkg::CSR_OUT_MIN:       cfg_out_min = data;
         pic_pkg::CSR_DEADBAND:      cfg_deadband = data[30:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Reprogram all registers once the block has gone idle.
   task automatic program_setting(input logic [31:0] gain, input logic [31:0] itime,
                                  input logic [31:0] omax, input logic [31:0] omin,
                                  input logic [31:0] dband);
      wait_drained();
      write_csr(pic_pkg::CSR_GAIN_P, gain);
      write_csr(pic_pkg::CSR_INTEGRAL_TIME, itime);
      write_csr(pic_pkg::CSR_OUT_MAX, omax);
      write_csr(pic_pkg::CSR_OUT_MIN, omin);
      write_csr(pic_pkg::CSR_DEADBAND, dband);
      @(negedge clock);
   endtask

   task automatic queue_item(input logic op, input logic signed [31:0] dt,
                             input logic signed [31:0] sp, input logic signed [31:0] mv);
      pi_req_type it;
      it.op = op;
      it.time_step = dt;
      it.setpoint = sp;
      it.measured = mv;
      pending_reqs.push_back(it);
   endtask

   task automatic program_random_setting();
      logic [31:0] gain, itime, omax, omin, dband, lo, hi;
      case ($urandom_range(0, 9))
         0:       gain = $urandom;
         1:       gain = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: gain = int'($urandom_range(0, 524288)) - 262144;
      endcase
      case ($urandom_range(0, 7))
         0, 1:    itime = 32'd0;
         2:       itime = $urandom & 32'h7FFF_FFFF;
         3:       itime = $urandom_range(1, 16);
         default: itime = $urandom_range(4096, 262144);
      endcase
      lo = -int'($urandom_range(16384, 524288));
      hi = $urandom_range(16384, 524288);
      case ($urandom_range(0, 7))
         0: begin
            // Crossed limits: the lower one ends up above the upper one.
            omax = lo;
            omin = hi;
         end
         1: begin
            omax = 32'h7FFF_FFFF;
            omin = 32'h8000_0000;
         end
         2: begin
            omax = $urandom;
            omin = $urandom;
         end
         default: begin
            omax = hi;
            omin = lo;
         end
      endcase
      case ($urandom_range(0, 7))
         0:       dband = 32'd0;
         1:       dband = $urandom & 32'h7FFF_FFFF;
         default: dband = $urandom_range(0, 3277);
      endcase
      program_setting(gain, itime, omax, omin, dband);
   endtask

   function automatic logic signed [31:0] random_level();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 3))
               0:       return 32'sh7FFF_FFFF;
               1:       return 32'sh8000_0000;
               2:       return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         2, 3:    return int'($urandom_range(0, 1048576)) - 524288;
         default: return int'($urandom_range(0, 8192)) - 4096;
      endcase
   endfunction

   // Time steps that the block processes, or else ones it must drop.
   function automatic logic signed [31:0] random_dt(input bit usable);
      if (usable) begin
         case ($urandom_range(0, 7))
            0:       return 32'sd1;
            1:       return pic_pkg::DT_MAX_Q;
            2:       return $urandom_range(1, 196608);
            3:       return -int'($urandom_range(1, 196608));
            4:       return $urandom | 32'h8000_0000;
            default: return $urandom_range(64, 6554);
         endcase
      end
      case ($urandom_range(0, 3))
         0:       return 32'sd0;
         1:       return $urandom_range(196609, 32'h7FFF_FFFF);
         2:       return $urandom;
         default: return pic_pkg::DT_MAX_Q + 32'sd1;
      endcase
   endfunction

   function automatic pi_req_type random_item();
      pi_req_type it;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      it.op = (pick < 5) ? pic_pkg::OP_CLEAR : pic_pkg::OP_STEP;
      it.time_step = random_dt(pick < 84);
      it.setpoint = random_level();
      if ($urandom_range(0, 3) == 0) begin
         it.measured = it.setpoint - (int'($urandom_range(0, 2620)) - 1310);
      end else begin
         it.measured = random_level();
      end
      return it;
   endfunction

   // Stimulus: directed cases under several settings, then random phases.
   initial begin
      pi_req_type it;
      int         counted;
      req_bus.valid = 1'b0;
      req_bus.op = pic_pkg::OP_STEP;
      req_bus.time_step = '0;
      req_bus.setpoint = '0;
      req_bus.measured = '0;
      rsp_bus.ready = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      req_idle_pct = 25;
      rsp_idle_pct = 25;

      // Default registers: zero gain, so the drive stays at zero.
      queue_item(pic_pkg::OP_STEP, 32'sd65536, 32'sd65536, 32'sd0);
      queue_item(pic_pkg::OP_CLEAR, 32'sd0, 32'sd0, 32'sd0);

      // Unit gain and integral time; dropped steps, time step limits and error extremes.
      program_setting(32'd65536, 32'd65536, 32'd262144, -32'sd262144, 32'd655);
      queue_item(pic_pkg::OP_STEP, 32'sd32768, 32'sd65536, 32'sd16384);
      queue_item(pic_pkg::OP_STEP, 32'sd0, 32'sd65536, 32'sd0);
      queue_item(pic_pkg::OP_STEP, pic_pkg::DT_MAX_Q + 32'sd1, 32'sd65536, 32'sd0);
      queue_item(pic_pkg::OP_STEP, pic_pkg::DT_MAX_Q, 32'sd131072, 32'sd0);
      queue_item(pic_pkg::OP_STEP, -32'sd65536, 32'sd0, 32'sd65536);
      queue_item(pic_pkg::OP_STEP, 32'sh8000_0000, 32'sd0, 32'sd0);
      queue_item(pic_pkg::OP_STEP, 32'sh7FFF_FFFF, 32'sd65536, 32'sd0);
      queue_item(pic_pkg::OP_STEP, 32'sd65536, 32'sd100, 32'sd0);
      queue_item(pic_pkg::OP_STEP, 32'sd65536, 32'sd655, 32'sd0);
      queue_item(pic_pkg::OP_STEP, 32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000);
      queue_item(pic_pkg::OP_STEP, 32'sd1, 32'sh8000_0000, 32'sh7FFF_FFFF);
      queue_item(pic_pkg::OP_CLEAR, -32'sd1, -32'sd1, -32'sd1);

      // Integral term off, negative gain, no deadband.
      program_setting(-32'sd98304, 32'd0, 32'd65536, -32'sd65536, 32'd0);
      queue_item(pic_pkg::OP_STEP, 32'sd65536, 32'sd32768, 32'sd0);
      queue_item(pic_pkg::OP_STEP, 32'sd131072, -32'sd32768, 32'sd0);
      queue_item(pic_pkg::OP_STEP, 32'sd1, 32'sd0, 32'sd0);

      // Crossed limits: the lower limit wins, also inside the deadband.
      program_setting(32'd131072, 32'd16384, -32'sd65536, 32'd65536, 32'd655);
      queue_item(pic_pkg::OP_STEP, 32'sd65536, 32'sd65536, 32'sd0);
      queue_item(pic_pkg::OP_STEP, 32'sd65536, 32'sd10, 32'sd0);

      // Most negative gain with the smallest integral time, so the ratio saturates.
      program_setting(32'h8000_0000, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
      queue_item(pic_pkg::OP_STEP, pic_pkg::DT_MAX_Q, 32'sh7FFF_FFFF, 32'sh8000_0000);
      queue_item(pic_pkg::OP_STEP, -pic_pkg::DT_MAX_Q, 32'sh8000_0000, 32'sh7FFF_FFFF);

      // Largest gain, integral time and deadband.
      program_setting(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h7FFF_FFFF);
      queue_item(pic_pkg::OP_STEP, 32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000);
      queue_item(pic_pkg::OP_STEP, pic_pkg::DT_MAX_Q, 32'sd1, 32'sd0);
      queue_item(pic_pkg::OP_CLEAR, 32'sd0, 32'sd0, 32'sd0);
      queue_item(pic_pkg::OP_STEP, 32'sd65536, -32'sd1, 32'sh7FFF_FFFF);

      // Random phases, each under a fresh setting; the last one runs without idling.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         program_random_setting();
         if (p == RANDOM_PHASES - 1) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else begin
            case ($urandom_range(0, 2))
               0:       req_idle_pct = 0;
               1:       req_idle_pct = 20;
               default: req_idle_pct = 45;
            endcase
            case ($urandom_range(0, 2))
               0:       rsp_idle_pct = 0;
               1:       rsp_idle_pct = 20;
               default: rsp_idle_pct = 45;
            endcase
         end
         counted = 0;
         while (counted < PHASE_STEPS) begin
            it = random_item();
            pending_reqs.push_back(it);
            if (it.op == pic_pkg::OP_CLEAR ||
                (it.time_step != 0 && it.time_step <= pic_pkg::DT_MAX_Q)) begin
               counted++;
            end
         end
      end

      wait_drained();
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
